// ===== rtl/lsh_pkg.sv =====
// Shared types, codes and sizes of the link setup handshake block.
package lsh_pkg;

    // Width of the reply timer (saturating tick counter).
    localparam int TIMER_WIDTH = 16;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    // Compare width wide enough for both the timer and the 16-bit timeout register.
    localparam int TMR_CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    localparam int FRAME_LEN = 5;
    localparam int FRAME_IDX_W = $clog2(FRAME_LEN);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROLE          = 3'd0,
        REG_FLAG_BYTE     = 3'd1,
        REG_ADDRESS_BYTE  = 3'd2,
        REG_SET_CODE      = 3'd3,
        REG_UA_CODE       = 3'd4,
        REG_TRY_LIMIT     = 3'd5,
        REG_TIMEOUT_TICKS = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_OPEN = 2'd0,
        OP_BYTE = 2'd1,
        OP_TICK = 2'd2
    } op_code_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_OPEN = 2'd2,
        PH_FAIL = 2'd3
    } link_phase_t;

    localparam logic ROLE_TX = 1'b0;

    typedef struct packed {
        logic        role;
        logic [7:0]  flag_byte;
        logic [7:0]  address_byte;
        logic [7:0]  set_code;
        logic [7:0]  ua_code;
        logic [7:0]  try_limit;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic [1:0] link_status;
    } out_item_t;

    // One command per accepted item: either a five-byte frame or a single empty result.
    typedef struct packed {
        logic        emit_frame;
        logic [7:0]  ctrl;
        link_phase_t status;
    } cmd_t;

endpackage

// ===== rtl/lsh_front.sv =====
// Front end: link phase, frame parser and reply timer; turns each item into a command.
module lsh_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  lsh_pkg::cfg_t    cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  lsh_pkg::in_item_t s_data,
    input  logic             q_full,
    output logic             q_push,
    output lsh_pkg::cmd_t    q_cmd
);
    import lsh_pkg::*;

    typedef enum logic [2:0] {
        PS_START = 3'd0,
        PS_FLAG  = 3'd1,
        PS_ADDR  = 3'd2,
        PS_CTRL  = 3'd3,
        PS_BCC   = 3'd4
    } parse_state_t;

    link_phase_t              phase_reg, phase_next;
    parse_state_t             ps_reg, ps_next;
    logic [7:0]               held_ctrl_reg, held_ctrl_next;
    logic [TIMER_WIDTH-1:0]   tick_reg, tick_next;
    logic [7:0]               tries_reg, tries_next;

    logic                     frame_done;
    logic [TMR_CMP_W-1:0]     limit;
    logic [TIMER_WIDTH-1:0]   tick_inc;
    logic [7:0]               tries_inc;
    logic [7:0]               tries_lim;
    logic [7:0]               rb;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign rb      = s_data.rx_byte;

    // Parser next state for the received byte.
    always_comb begin
        ps_next        = ps_reg;
        held_ctrl_next = held_ctrl_reg;
        frame_done     = 1'b0;
        case (ps_reg)
            PS_FLAG: begin
                if (rb == cfg.address_byte) ps_next = PS_ADDR;
                else if (rb != cfg.flag_byte) ps_next = PS_START;
            end
            PS_ADDR: begin
                if (rb == cfg.set_code || rb == cfg.ua_code) begin
                    ps_next        = PS_CTRL;
                    held_ctrl_next = rb;
                end else if (rb == cfg.flag_byte) begin
                    ps_next = PS_FLAG;
                end else begin
                    ps_next = PS_START;
                end
            end
            PS_CTRL: begin
                if (rb == (cfg.address_byte ^ held_ctrl_reg)) ps_next = PS_BCC;
                else if (rb == cfg.flag_byte) ps_next = PS_FLAG;
                else ps_next = PS_START;
            end
            PS_BCC: begin
                ps_next    = PS_START;
                frame_done = (rb == cfg.flag_byte);
            end
            default: begin
                ps_next = (rb == cfg.flag_byte) ? PS_FLAG : PS_START;
            end
        endcase
    end

    // Timer limit: zero acts as one, clip to the counter range.
    always_comb begin
        limit = TMR_CMP_W'(cfg.timeout_ticks);
        if (limit == '0) limit = TMR_CMP_W'(1);
        if (limit > TMR_CMP_W'(TIMER_MAX)) limit = TMR_CMP_W'(TIMER_MAX);
        tick_inc  = (tick_reg == TIMER_MAX) ? tick_reg : tick_reg + 1'b1;
        tries_inc = (tries_reg == 8'hFF) ? tries_reg : tries_reg + 8'd1;
        tries_lim = (cfg.try_limit == 8'd0) ? 8'd1 : cfg.try_limit;
    end

    always_comb begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        tries_next     = tries_reg;
        q_cmd.emit_frame = 1'b0;
        q_cmd.ctrl       = cfg.set_code;
        case (s_data.operation)
            OP_OPEN: begin
                phase_next       = PH_WAIT;
                tick_next        = '0;
                tries_next       = '0;
                q_cmd.emit_frame = (cfg.role == ROLE_TX);
            end
            OP_BYTE: begin
                if (phase_reg == PH_WAIT && frame_done) begin
                    phase_next       = PH_OPEN;
                    q_cmd.emit_frame = (cfg.role != ROLE_TX);
                    q_cmd.ctrl       = cfg.ua_code;
                end
            end
            OP_TICK: begin
                if (phase_reg == PH_WAIT && cfg.role == ROLE_TX) begin
                    tick_next = tick_inc;
                    if (TMR_CMP_W'(tick_inc) >= limit) begin
                        tick_next  = '0;
                        tries_next = tries_inc;
                        if (tries_inc >= tries_lim) phase_next = PH_FAIL;
                        else q_cmd.emit_frame = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        q_cmd.status = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            ps_reg        <= PS_START;
            held_ctrl_reg <= '0;
            tick_reg      <= '0;
            tries_reg     <= '0;
        end else if (q_push) begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            tries_reg  <= tries_next;
            case (s_data.operation)
                OP_OPEN: ps_reg <= PS_START;
                OP_BYTE: begin
                    if (phase_reg == PH_WAIT) begin
                        ps_reg        <= ps_next;
                        held_ctrl_reg <= held_ctrl_next;
                    end
                end
                OP_TICK: begin
                    // restart the parser on each timeout
                    if (phase_reg == PH_WAIT && cfg.role == ROLE_TX &&
                        TMR_CMP_W'(tick_inc) >= limit) begin
                        ps_reg <= PS_START;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/lsh_queue.sv =====
// Short command queue between the front end and the frame emitter.
module lsh_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lsh_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output lsh_pkg::cmd_t head_cmd
);
    import lsh_pkg::*;

    cmd_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/lsh_emit.sv =====
// Back end: expands each command into result items behind an output register.
module lsh_emit (
    input  logic               aclk,
    input  logic               aresetn,
    input  lsh_pkg::cfg_t      cfg,
    input  logic               head_valid,
    input  lsh_pkg::cmd_t      head_cmd,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output lsh_pkg::out_item_t m_data
);
    import lsh_pkg::*;

    localparam logic [FRAME_IDX_W-1:0] POS_OPEN_FLAG  = FRAME_IDX_W'(0);
    localparam logic [FRAME_IDX_W-1:0] POS_ADDRESS    = FRAME_IDX_W'(1);
    localparam logic [FRAME_IDX_W-1:0] POS_CONTROL    = FRAME_IDX_W'(2);
    localparam logic [FRAME_IDX_W-1:0] POS_CHECK      = FRAME_IDX_W'(3);
    localparam logic [FRAME_IDX_W-1:0] POS_CLOSE_FLAG = FRAME_IDX_W'(FRAME_LEN - 1);

    logic [FRAME_IDX_W-1:0] idx_reg;
    logic                   m_valid_reg;
    out_item_t              m_data_reg;
    logic                   load;
    logic                   is_last;
    logic [7:0]             frame_byte;

    assign load    = head_valid && (!m_valid_reg || m_ready);
    assign is_last = !head_cmd.emit_frame || (idx_reg == POS_CLOSE_FLAG);
    assign pop     = load && is_last;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        case (idx_reg)
            POS_OPEN_FLAG:  frame_byte = cfg.flag_byte;
            POS_ADDRESS:    frame_byte = cfg.address_byte;
            POS_CONTROL:    frame_byte = head_cmd.ctrl;
            POS_CHECK:      frame_byte = cfg.address_byte ^ head_cmd.ctrl;
            default:        frame_byte = cfg.flag_byte;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.tx_valid    <= head_cmd.emit_frame;
            m_data_reg.tx_byte     <= head_cmd.emit_frame ? frame_byte : 8'd0;
            m_data_reg.last        <= is_last;
            m_data_reg.link_status <= head_cmd.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (load) idx_reg <= is_last ? '0 : idx_reg + 1'b1;
        end
    end

endmodule

// ===== rtl/link_setup_handshake.sv =====
// Top level of the link setup handshake: configuration registers and the front/back pipeline.
//
// Input channel s_*: one item per handshake, an open command, a received line
// byte or one timer tick. Result channel m_*: every item yields one result with
// tx_valid low, or five results carrying a SET or UA frame; last marks the final
// result of an item and link_status gives the link phase after that item.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index at the edge;
// the user must use it only while the block is idle; the block itself does not enforce this.
// With the queue empty and the output register free, the first result of an item
// passes through the queue entry and then the output register. The block takes
// one item per cycle while no frames are sent and the receiver takes every result;
// a frame's five results leave the single output register one after another, so
// the emitter sets the rate for frame items.
// A four-entry command queue sits between the front end and the emitter; the
// front keeps accepting items until that queue is full, so a stalled m_ready
// backs up into s_ready after four commands are pending.
// Reset (aresetn low, synchronous): registers to defaults, link idle, parser at
// start, queue empty, no result valid.
module link_setup_handshake (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lsh_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lsh_pkg::out_item_t                  m_data
);
    import lsh_pkg::*;

    cfg_t cfg_reg;
    logic q_full, q_push, q_pop, q_head_valid;
    cmd_t q_cmd, q_head;

    // Register file; writes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.role          <= 1'b0;
            cfg_reg.flag_byte     <= 8'd126;
            cfg_reg.address_byte  <= 8'd3;
            cfg_reg.set_code      <= 8'd3;
            cfg_reg.ua_code       <= 8'd7;
            cfg_reg.try_limit     <= 8'd3;
            cfg_reg.timeout_ticks <= 16'd3;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_ROLE:          cfg_reg.role          <= cfg_wdata[0];
                REG_FLAG_BYTE:     cfg_reg.flag_byte     <= cfg_wdata[7:0];
                REG_ADDRESS_BYTE:  cfg_reg.address_byte  <= cfg_wdata[7:0];
                REG_SET_CODE:      cfg_reg.set_code      <= cfg_wdata[7:0];
                REG_UA_CODE:       cfg_reg.ua_code       <= cfg_wdata[7:0];
                REG_TRY_LIMIT:     cfg_reg.try_limit     <= cfg_wdata[7:0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Classify each item and advance the link state.
    lsh_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    // Hold pending commands so the two sides stall independently.
    lsh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head)
    );

    // Drive the result items, one per cycle when the receiver takes them.
    lsh_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head_cmd   (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // A result that is not last is always a frame byte.
    a_nonlast_is_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> m_data.tx_valid)
        else $error("non-last result without a frame byte");

    // The closing byte of a frame is the flag.
    a_frame_closes_on_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last && m_data.tx_valid) |-> (m_data.tx_byte == cfg_reg.flag_byte))
        else $error("frame does not end with the flag byte");

    // An empty result carries a zero byte and is the last result of its item.
    a_empty_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.tx_valid) |-> (m_data.tx_byte == 8'd0 && m_data.last))
        else $error("empty result is malformed");

    // An accepted item is written into the queue and then loaded into the output
    // register, after which a result is valid.
    a_accept_then_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##2 m_valid)
        else $error("accepted item produced no pending result");

endmodule

// ===== verif/link_setup_handshake_test.sv =====
// Self-checking testbench for the link setup handshake block (SET/UA link opening).
module link_setup_handshake_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lsh_pkg::*;

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Receiver hold-off used to back the block up into its input.
    localparam int LONG_HOLD = 300;
    // Cycles without any handshake or register write before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Items per random phase; seven phases plus the directed part give roughly 460 items.
    localparam int PHASE_ITEMS = 60;

    // Register values right after reset.
    localparam cfg_t CFG_RESET = '{
        role: ROLE_TX, flag_byte: 8'h7E, address_byte: 8'h03, set_code: 8'h03,
        ua_code: 8'h07, try_limit: 8'd3, timeout_ticks: 16'd3
    };

    // Position of the frame parser inside an incoming frame.
    typedef enum logic [2:0] {
        HUNT      = 3'd0,
        SAW_FLAG  = 3'd1,
        SAW_ADDR  = 3'd2,
        SAW_CTRL  = 3'd3,
        SAW_CHECK = 3'd4
    } frame_pos_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    link_setup_handshake uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Stimulus and scoreboard storage.
    in_item_t  line_items[$];   // items waiting for the driver
    out_item_t due_results[$];  // results the block still owes, oldest first
    int        queued        = 0;
    int        fault_count   = 0;
    int        quiet_cycles  = 0;
    logic      s_taken       = 1'b0;

    // Idling knobs, in percent, set per phase by the stimulus thread.
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        holds_asked    = 0;
    int        holds_done     = 0;
    int        hold_left      = 0;

    // Local copy of the registers and of the link state.
    cfg_t                   link_cfg  = CFG_RESET;
    link_phase_t            phase_now = PH_IDLE;
    frame_pos_t             frame_pos = HUNT;
    logic [7:0]             held_ctrl = '0;
    logic [TIMER_WIDTH-1:0] tick_cnt  = '0;
    logic [7:0]             tries_cnt = '0;

    // Clock and the single reset pulse.
    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Feed one line byte to the parser; true when a complete frame just closed.
    function automatic logic frame_closed(logic [7:0] b);
        logic done = 1'b0;
        case (frame_pos)
            SAW_FLAG: begin
                if (b == link_cfg.address_byte) frame_pos = SAW_ADDR;
                else if (b != link_cfg.flag_byte) frame_pos = HUNT;
            end
            SAW_ADDR: begin
                if (b == link_cfg.set_code || b == link_cfg.ua_code) begin
                    frame_pos = SAW_CTRL;
                    held_ctrl = b;
                end else if (b == link_cfg.flag_byte) begin
                    frame_pos = SAW_FLAG;
                end else begin
                    frame_pos = HUNT;
                end
            end
            SAW_CTRL: begin
                if (b == (link_cfg.address_byte ^ held_ctrl)) frame_pos = SAW_CHECK;
                else if (b == link_cfg.flag_byte) frame_pos = SAW_FLAG;
                else frame_pos = HUNT;
            end
            SAW_CHECK: begin
                frame_pos = HUNT;
                done = (b == link_cfg.flag_byte);
            end
            default: begin
                // Hunt for the opening flag; anything else keeps hunting.
                frame_pos = (b == link_cfg.flag_byte) ? SAW_FLAG : HUNT;
            end
        endcase
        return done;
    endfunction

    // Advance the link state by one accepted item and queue the results it owes.
    function automatic void advance_link(in_item_t it);
        logic                 send = 1'b0;
        logic [7:0]           ctrl = '0;
        logic [7:0]           frame [FRAME_LEN];
        logic [TMR_CMP_W-1:0] limit;
        logic [7:0]           tries_cap;
        out_item_t            r;
        case (it.operation)
            OP_OPEN: begin
                // Open restarts the handshake from scratch, whatever the phase.
                phase_now = PH_WAIT;
                frame_pos = HUNT;
                tick_cnt  = '0;
                tries_cnt = '0;
                if (link_cfg.role == ROLE_TX) begin
                    send = 1'b1;
                    ctrl = link_cfg.set_code;
                end
            end
            OP_BYTE: begin
                if (phase_now == PH_WAIT && frame_closed(it.rx_byte)) begin
                    phase_now = PH_OPEN;
                    if (link_cfg.role != ROLE_TX) begin
                        send = 1'b1;
                        ctrl = link_cfg.ua_code;
                    end
                end
            end
            OP_TICK: begin
                // Only a waiting transmitter keeps time; the receiver waits forever.
                if (phase_now == PH_WAIT && link_cfg.role == ROLE_TX) begin
                    limit = (link_cfg.timeout_ticks == '0) ? TMR_CMP_W'(1)
                                                           : TMR_CMP_W'(link_cfg.timeout_ticks);
                    if (limit > TMR_CMP_W'(TIMER_MAX)) limit = TMR_CMP_W'(TIMER_MAX);
                    tries_cap = (link_cfg.try_limit == '0) ? 8'd1 : link_cfg.try_limit;
                    if (tick_cnt != TIMER_MAX) tick_cnt++;
                    if (TMR_CMP_W'(tick_cnt) >= limit) begin
                        tick_cnt  = '0;
                        if (tries_cnt != 8'hFF) tries_cnt++;
                        frame_pos = HUNT;
                        if (tries_cnt >= tries_cap) begin
                            phase_now = PH_FAIL;
                        end else begin
                            send = 1'b1;
                            ctrl = link_cfg.set_code;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (send) begin
            frame = '{link_cfg.flag_byte, link_cfg.address_byte, ctrl,
                      link_cfg.address_byte ^ ctrl, link_cfg.flag_byte};
            for (int k = 0; k < FRAME_LEN; k++) begin
                r             = '0;
                r.tx_valid    = 1'b1;
                r.tx_byte     = frame[k];
                r.last        = (k == FRAME_LEN - 1);
                r.link_status = phase_now;
                due_results.push_back(r);
            end
        end else begin
            // Nothing to send: one empty result that closes the item.
            r             = '0;
            r.last        = 1'b1;
            r.link_status = phase_now;
            due_results.push_back(r);
        end
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fault_count++;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Driver, receiver and monitor
    // ---------------------------------------------------------------------

    // Driver: change inputs on the falling edge; hold an item until it is taken.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_taken)) begin
            if (line_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= line_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (holds_done != holds_asked) begin
            hold_left  <= LONG_HOLD;
            holds_done <= holds_done + 1;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: sample both channels on the rising edge.
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            s_taken      <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            s_taken <= s_valid && s_ready;
            // Check the result side first so an item taken on this edge
            // cannot satisfy a result on the same edge.
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: tx_valid %0d tx_byte 0x%0h last %0d status %0d",
                           m_data.tx_valid, m_data.tx_byte, m_data.last, m_data.link_status);
                    fault_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("tx_valid", 8'(want.tx_valid), 8'(m_data.tx_valid));
                    check_field("tx_byte", want.tx_byte, m_data.tx_byte);
                    check_field("last", 8'(want.last), 8'(m_data.last));
                    check_field("link_status", 8'(want.link_status), 8'(m_data.link_status));
                end
            end
            if (s_valid && s_ready) advance_link(s_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: give up when nothing moves for too long.
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $error("no handshake for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    function automatic void offer(logic [1:0] op, logic [7:0] b);
        in_item_t it;
        it.operation = op;
        it.rx_byte   = b;
        line_items.push_back(it);
        queued++;
    endfunction

    // Queue a frame built from the current registers; damage corrupts one byte.
    function automatic void offer_frame(logic [7:0] ctrl, bit damage);
        logic [7:0] seq [FRAME_LEN];
        int         spot;
        seq = '{link_cfg.flag_byte, link_cfg.address_byte, ctrl,
                link_cfg.address_byte ^ ctrl, link_cfg.flag_byte};
        if (damage) begin
            spot      = $urandom_range(0, FRAME_LEN - 1);
            seq[spot] = 8'($urandom);
        end
        foreach (seq[k]) offer(OP_BYTE, seq[k]);
    endfunction

    // Mostly well-formed exchanges with random content, some broken frames and noise.
    function automatic void fill_random(int n);
        int stop;
        int pick;
        int burst;
        stop = queued + n;
        while (queued < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                offer(OP_OPEN, 8'($urandom));
            end else if (pick < 47) begin
                repeat ($urandom_range(0, 2)) offer(OP_BYTE, 8'($urandom));
                if ($urandom_range(0, 3) == 0) offer(OP_BYTE, link_cfg.flag_byte);
                offer_frame($urandom_range(0, 1) ? link_cfg.set_code : link_cfg.ua_code, 1'b0);
            end else if (pick < 60) begin
                offer_frame(pick[0] ? 8'($urandom) : link_cfg.set_code, 1'b1);
            end else if (pick < 82) begin
                // Tick bursts sized so that timeouts actually fire.
                burst = (link_cfg.timeout_ticks > 6) ? 7 : int'(link_cfg.timeout_ticks) + 1;
                repeat ($urandom_range(1, burst)) offer(OP_TICK, 8'($urandom));
            end else begin
                offer(2'($urandom), 8'($urandom));
            end
        end
    endfunction

    // Wait until every item is taken and every owed result has arrived.
    task automatic drain_link();
        while (line_items.size() != 0 || s_valid || due_results.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    // Write one register and mirror it locally; upper data bits carry junk.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_ROLE:          link_cfg.role          = data[0];
            REG_FLAG_BYTE:     link_cfg.flag_byte     = data[7:0];
            REG_ADDRESS_BYTE:  link_cfg.address_byte  = data[7:0];
            REG_SET_CODE:      link_cfg.set_code      = data[7:0];
            REG_UA_CODE:       link_cfg.ua_code       = data[7:0];
            REG_TRY_LIMIT:     link_cfg.try_limit     = data[7:0];
            REG_TIMEOUT_TICKS: link_cfg.timeout_ticks = data[15:0];
            default: ;
        endcase
    endtask

    task automatic setup_link(logic role, logic [7:0] flag, logic [7:0] addr,
                              logic [7:0] set_c, logic [7:0] ua_c, logic [7:0] tries,
                              logic [15:0] ticks);
        write_reg(REG_ROLE, {15'($urandom), role});
        write_reg(REG_FLAG_BYTE, {8'($urandom), flag});
        write_reg(REG_ADDRESS_BYTE, {8'($urandom), addr});
        write_reg(REG_SET_CODE, {8'($urandom), set_c});
        write_reg(REG_UA_CODE, {8'($urandom), ua_c});
        write_reg(REG_TRY_LIMIT, {8'($urandom), tries});
        write_reg(REG_TIMEOUT_TICKS, ticks);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        fill_random(PHASE_ITEMS);
        drain_link();
    endtask

    initial begin
        wait (aresetn === 1'b1);

        // Directed part on the reset register values, no idling.
        offer(OP_TICK, 8'h00);                 // tick while idle: ignored
        offer(OP_BYTE, 8'hFF);                 // byte while idle: ignored
        offer(OP_UNUSED, 8'hA5);               // unused operation code: ignored
        offer(OP_OPEN, 8'h00);                 // transmitter sends SET
        offer_frame(link_cfg.ua_code, 1'b0);   // UA reply opens the link
        offer(OP_TICK, 8'hFF);                 // tick while open: ignored
        offer(OP_OPEN, 8'hFF);                 // reopen an open link
        repeat (9) offer(OP_TICK, 8'h00);      // two resends, then the link fails
        offer(OP_BYTE, 8'h7E);                 // byte after failure: ignored
        offer(OP_OPEN, 8'h00);
        offer(OP_OPEN, 8'h00);                 // open while already waiting
        offer(OP_BYTE, link_cfg.flag_byte);    // doubled flag: parser resyncs
        offer_frame(link_cfg.set_code, 1'b0);  // SET as reply also opens the link
        drain_link();

        // Extreme registers, fastest timeout; the receiver holds off long enough
        // for the block to fill up and stall its input.
        setup_link(1'b0, 8'h00, 8'hFF, 8'h80, 8'h01, 8'd1, 16'd1);
        holds_asked++;
        run_phase(0, 0);

        // Receiver role, opposite extremes; the timer must never matter here.
        setup_link(1'b1, 8'hFF, 8'h00, 8'h7F, 8'hFE, 8'hFF, 16'hFFFF);
        run_phase(58, 0);

        // Zero tries and zero timeout both behave as one.
        setup_link(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'd0, 16'd0);
        run_phase(0, 58);

        setup_link(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 16'($urandom));
        run_phase(20, 20);

        // Switch back to transmitter with the link possibly still waiting.
        setup_link(1'b0, 8'h7E, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom_range(1, 4)), 16'($urandom_range(1, 5)));
        run_phase(0, 0);

        setup_link(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'd2, 16'd2);
        run_phase(58, 0);

        setup_link(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'd3, 16'd3);
        run_phase(0, 58);

        // Settle, then report.
        drain_link();
        repeat (20) @(negedge aclk);
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
